FILE: sv/pngunf_pkg.sv
package pngunf_pkg;

  localparam int MAX_ROW_BYTES   = 16384;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int ROWPIX_W = 15;
  localparam int BPP_W    = 4;
  localparam int ROWS_W   = 16;
  localparam int RB_W     = ROWPIX_W + BPP_W;
  localparam int CW       = $clog2(MAX_ROW_BYTES + 1);
  localparam int AW       = $clog2(MAX_ROW_BYTES);
  localparam int KW       = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int CNT_W    = $clog2(CW);

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;
  localparam logic [7:0] FILT_LIMIT = 8'd5;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_FILTER = 2'd1;
  localparam logic [1:0] ST_OVERRUN    = 2'd2;

  localparam logic [1:0] REG_ROW_PIXELS = 2'd0;
  localparam logic [1:0] REG_BPP        = 2'd1;
  localparam logic [1:0] REG_IMAGE_ROWS = 2'd2;

  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_STATUS,
    TOK_DATA
  } tok_e;

  typedef struct packed {
    logic [ROWPIX_W-1:0] row_pixels;
    logic [BPP_W-1:0]    bytes_per_pixel;
    logic [ROWS_W-1:0]   image_rows;
  } cfg_t;

  typedef struct packed {
    tok_e          kind;
    logic          clr;
    logic [1:0]    status;
    logic [7:0]    data;
    logic [2:0]    filt;
    logic [AW-1:0] idx;
    logic [KW-1:0] k;
    logic          a_ok;
    logic          first;
    logic          row_end;
    logic          image_end;
  } tok_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [KW-1:0] k;
  } rem_t;

endpackage

FILE: sv/pngunf_ram.sv
module pngunf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/pngunf_rem.sv
module pngunf_rem import pngunf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CW-1:0]    dividend_i,
  input  logic [BPP_W-1:0] divisor_i,
  output rem_t             rem_o
);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [BPP_W-1:0] r_q;
  logic [BPP_W:0]   r_shift;
  logic [BPP_W:0]   r_sub;
  logic [BPP_W-1:0] r_d;

  always_comb begin
    r_shift = {r_q, dividend_i[cnt_q]};
    r_sub   = r_shift - {1'b0, divisor_i};
    r_d     = (r_shift >= {1'b0, divisor_i}) ? r_sub[BPP_W-1:0] : r_shift[BPP_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      r_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(CW - 1);
        r_q    <= '0;
      end else if (busy_q) begin
        r_q   <= r_d;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rem_o.busy = busy_q | done_q;
  assign rem_o.done = done_q;
  assign rem_o.k    = r_q[KW-1:0];

endmodule

FILE: sv/pngunf_ctrl.sv
module pngunf_ctrl import pngunf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    filtered_byte_i,
  input  logic          image_start_i,
  output logic          in_ready_o,
  input  logic          hold_i,
  input  logic          s1_ready_i,
  input  cfg_t          cfg_i,
  input  rem_t          rem_i,
  output logic [CW-1:0] dividend_o,
  output logic          tok_valid_o,
  output tok_t          tok_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o
);

  logic [CW-1:0]     col_q, col_d, col_e, idx;
  logic [ROWS_W-1:0] row_q, row_d, row_e;
  logic [2:0]        filt_q, filt_d, filt_e;
  logic              first_q, first_d, first_e;
  logic              err_q, err_d, err_e;
  logic [KW-1:0]     k_q, k_d, k_e;
  logic [RB_W-1:0]   rb;
  logic              oversize;
  logic              acc;

  assign in_ready_o  = s1_ready_i && !hold_i;
  assign acc         = in_valid_i && in_ready_o;
  assign tok_valid_o = acc;
  assign dividend_o  = col_q - CW'(1);

  always_comb begin
    rb = RB_W'(cfg_i.row_pixels) * RB_W'(cfg_i.bytes_per_pixel);
    oversize = (cfg_i.row_pixels == '0) || (cfg_i.bytes_per_pixel == '0) ||
               (cfg_i.bytes_per_pixel > BPP_W'(MAX_PIXEL_BYTES)) ||
               (rb > RB_W'(MAX_ROW_BYTES));

    col_e   = image_start_i ? '0 : col_q;
    row_e   = image_start_i ? '0 : row_q;
    filt_e  = image_start_i ? FILT_NONE : filt_q;
    first_e = image_start_i ? 1'b1 : first_q;
    err_e   = image_start_i ? 1'b0 : err_q;
    k_e     = image_start_i ? '0 : k_q;
    idx     = col_e - CW'(1);

    col_d   = col_e;
    row_d   = row_e;
    filt_d  = filt_e;
    first_d = first_e;
    err_d   = err_e;
    k_d     = k_e;

    tok_o.kind      = TOK_NONE;
    tok_o.clr       = image_start_i;
    tok_o.status    = ST_OK;
    tok_o.data      = filtered_byte_i;
    tok_o.filt      = filt_e;
    tok_o.idx       = idx[AW-1:0];
    tok_o.k         = k_e;
    tok_o.a_ok      = RB_W'(idx) >= RB_W'(cfg_i.bytes_per_pixel);
    tok_o.first     = first_e;
    tok_o.row_end   = 1'b0;
    tok_o.image_end = 1'b0;
    rd_en_o         = 1'b0;

    if (oversize) begin
      tok_o.kind   = TOK_STATUS;
      tok_o.status = ST_OVERRUN;
    end else if (err_e) begin
      tok_o.kind   = TOK_STATUS;
      tok_o.status = ST_BAD_FILTER;
    end else if (row_e >= cfg_i.image_rows) begin
      tok_o.kind   = TOK_STATUS;
      tok_o.status = ST_OVERRUN;
    end else if (col_e == '0) begin
      if (filtered_byte_i >= FILT_LIMIT) begin
        err_d        = 1'b1;
        tok_o.kind   = TOK_STATUS;
        tok_o.status = ST_BAD_FILTER;
      end else begin
        filt_d = filtered_byte_i[2:0];
        col_d  = CW'(1);
        k_d    = '0;
      end
    end else if (RB_W'(idx) >= rb) begin
      col_d        = '0;
      tok_o.kind   = TOK_STATUS;
      tok_o.status = ST_OVERRUN;
    end else begin
      tok_o.kind = TOK_DATA;
      rd_en_o    = acc;
      if (RB_W'(col_e) >= rb) begin
        col_d           = '0;
        first_d         = 1'b0;
        row_d           = (row_e == '1) ? row_e : row_e + 1'b1;
        tok_o.row_end   = 1'b1;
        tok_o.image_end = row_d >= cfg_i.image_rows;
      end else begin
        col_d = col_e + 1'b1;
        k_d   = (BPP_W'(k_e) + 1'b1 == cfg_i.bytes_per_pixel) ? '0 : k_e + 1'b1;
      end
    end
  end

  assign rd_addr_o = idx[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      filt_q  <= FILT_NONE;
      first_q <= 1'b1;
      err_q   <= 1'b0;
      k_q     <= '0;
    end else if (rem_i.done) begin
      k_q <= rem_i.k;
    end else if (acc) begin
      col_q   <= col_d;
      row_q   <= row_d;
      filt_q  <= filt_d;
      first_q <= first_d;
      err_q   <= err_d;
      k_q     <= k_d;
    end
  end

  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!hold_i && col_q != '0 && cfg_i.bytes_per_pixel != '0 &&
     cfg_i.bytes_per_pixel <= BPP_W'(MAX_PIXEL_BYTES))
    |-> (BPP_W'(k_q) < cfg_i.bytes_per_pixel))
    else $error("pixel phase out of range");

endmodule

FILE: sv/pngunf_recon.sv
module pngunf_recon import pngunf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tok_valid_i,
  input  tok_t          tok_i,
  output logic          s1_ready_o,
  input  logic [7:0]    rd_data_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [7:0]    wr_data_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    pixel_byte_o,
  output logic [1:0]    status_o,
  output logic          row_end_o,
  output logic          image_end_o
);

  function automatic logic [9:0] abs10(input logic signed [9:0] v);
    abs10 = (v < 0) ? 10'(-v) : 10'(v);
  endfunction

  logic          s1_valid_q;
  tok_t          s1_q;
  logic          has_res, go;
  logic [7:0]    left_q [MAX_PIXEL_BYTES];
  logic [7:0]    ul_q [MAX_PIXEL_BYTES];
  logic [7:0]    a, b, c, pred, x;
  logic [8:0]    sum_ab;
  logic [9:0]    pa, pb, pc;
  logic          out_valid_q;
  logic [7:0]    px_q;
  logic [1:0]    st_q;
  logic          re_q, ie_q;

  assign has_res    = s1_q.kind != TOK_NONE;
  assign go         = s1_valid_q && (!has_res || !out_valid_q || out_ready_i);
  assign s1_ready_o = !s1_valid_q || go;

  always_comb begin
    a      = s1_q.a_ok ? left_q[s1_q.k] : 8'd0;
    b      = s1_q.first ? 8'd0 : rd_data_i;
    c      = (s1_q.a_ok && !s1_q.first) ? ul_q[s1_q.k] : 8'd0;
    sum_ab = {1'b0, a} + {1'b0, b};
    pa     = abs10($signed({2'b00, b}) - $signed({2'b00, c}));
    pb     = abs10($signed({2'b00, a}) - $signed({2'b00, c}));
    pc     = abs10($signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0}));
    case (s1_q.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = 8'd0;
    endcase
    x = s1_q.data + pred;
  end

  assign wr_en_o   = go && (s1_q.kind == TOK_DATA);
  assign wr_addr_o = s1_q.idx;
  assign wr_data_o = x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (tok_valid_i) begin
      s1_valid_q <= 1'b1;
    end else if (go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_valid_i) begin
      s1_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_q[i] <= 8'd0;
        ul_q[i]   <= 8'd0;
      end
    end else if (go) begin
      if (s1_q.clr) begin
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
          left_q[i] <= 8'd0;
          ul_q[i]   <= 8'd0;
        end
      end else if (s1_q.kind == TOK_DATA) begin
        left_q[s1_q.k] <= x;
        ul_q[s1_q.k]   <= b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && has_res) begin
      if (s1_q.kind == TOK_DATA) begin
        px_q <= x;
        st_q <= ST_OK;
        re_q <= s1_q.row_end;
        ie_q <= s1_q.image_end;
      end else begin
        px_q <= 8'd0;
        st_q <= s1_q.status;
        re_q <= 1'b0;
        ie_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = px_q;
  assign status_o     = st_q;
  assign row_end_o    = re_q;
  assign image_end_o  = ie_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (pixel_byte_o == 8'd0 && !row_end_o))
    else $error("error word carries data");

  a_image_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && image_end_o) |-> row_end_o)
    else $error("image end without row end");

  a_write_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (s1_valid_q && s1_q.kind == TOK_DATA && !s1_q.clr))
    else $error("line store written by a non-data word");

endmodule

FILE: sv/png_scanline_unfilter_top.sv
// PNG scanline unfilter: takes the inflated stream one byte per word, a filter
// type at each row start and then row_pixels*bytes_per_pixel filtered bytes, and
// returns one reconstructed byte per data byte (or a status word for a bad
// filter type, data beyond the image, or an oversize row). Throughput is one
// byte per cycle, unless the output or a register write stalls it, through two
// stages: the control stage issues the line store read, the next stage combines
// the above byte with the left and above-left histories and writes the result
// back into the line store. An accepted byte's result word goes from the stage
// register to the output register, held back while the output stalls. A filter
// byte gives no word. After a write to bytes_per_pixel the input holds off
// while the pixel phase of the current column is recomputed one bit per cycle.
// The line store is never cleared: the first row of each image masks it.
module png_scanline_unfilter_top import pngunf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  filtered_byte_i,
  input  logic        image_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  pixel_byte_o,
  output logic [1:0]  status_o,
  output logic        row_end_o,
  output logic        image_end_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t          cfg_q;
  logic          cfg_wr;
  logic [1:0]    reg_idx;
  rem_t          rem;
  logic [CW-1:0] dividend;
  logic          s1_ready;
  logic          tok_valid;
  tok_t          tok;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    rd_data, wr_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_pixels      <= ROWPIX_W'(1);
      cfg_q.bytes_per_pixel <= BPP_W'(4);
      cfg_q.image_rows      <= ROWS_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ROW_PIXELS: cfg_q.row_pixels      <= pwdata[ROWPIX_W-1:0];
        REG_BPP:        cfg_q.bytes_per_pixel <= pwdata[BPP_W-1:0];
        REG_IMAGE_ROWS: cfg_q.image_rows      <= pwdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROW_PIXELS: prdata = 32'(cfg_q.row_pixels);
      REG_BPP:        prdata = 32'(cfg_q.bytes_per_pixel);
      REG_IMAGE_ROWS: prdata = 32'(cfg_q.image_rows);
      default:        prdata = 32'd0;
    endcase
  end

  pngunf_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_wr && reg_idx == REG_BPP),
    .dividend_i (dividend),
    .divisor_i  (cfg_q.bytes_per_pixel),
    .rem_o      (rem)
  );

  pngunf_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .filtered_byte_i (filtered_byte_i),
    .image_start_i   (image_start_i),
    .in_ready_o      (in_ready_o),
    .hold_i          (cfg_wr || rem.busy),
    .s1_ready_i      (s1_ready),
    .cfg_i           (cfg_q),
    .rem_i           (rem),
    .dividend_o      (dividend),
    .tok_valid_o     (tok_valid),
    .tok_o           (tok),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr)
  );

  pngunf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  pngunf_recon u_recon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_valid_i  (tok_valid),
    .tok_i        (tok),
    .s1_ready_o   (s1_ready),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_byte_o (pixel_byte_o),
    .status_o     (status_o),
    .row_end_o    (row_end_o),
    .image_end_o  (image_end_o)
  );

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("line store read and write hit the same entry");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pngunf_pkg::*;

  localparam int RANDOM_WORDS  = 1000;
  localparam int SETTLE_CYCLES = 20;
  localparam int N_DIRECTED    = 31;

  typedef struct packed {
    logic [7:0] px;
    logic [1:0] st;
    logic       row_end;
    logic       image_end;
  } pixel_word_t;

  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_WORD
  } check_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    check_e      chk;
    pixel_word_t want;
  } feed_word_t;

  typedef enum logic {
    ROW_CFG,
    ROW_WORD
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    feed_word_t  word;
  } directed_row_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_e;

  localparam pixel_word_t NO_WORD  = '{8'h00, ST_OK, 1'b0, 1'b0};
  localparam pixel_word_t OVR_WORD = '{8'h00, ST_OVERRUN, 1'b0, 1'b0};
  localparam pixel_word_t BAD_WORD = '{8'h00, ST_BAD_FILTER, 1'b0, 1'b0};
  localparam feed_word_t  CFG_ONLY = '{8'h00, 1'b0, CHK_NONE, NO_WORD};

  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h00, 1'b1, CHK_NONE, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h00, 1'b0, CHK_WORD, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0,
      '{8'hFF, 1'b0, CHK_WORD, '{8'hFF, ST_OK, 1'b0, 1'b0}}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0,
      '{8'h80, 1'b0, CHK_WORD, '{8'h80, ST_OK, 1'b0, 1'b0}}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0,
      '{8'h7F, 1'b0, CHK_WORD, '{8'h7F, ST_OK, 1'b1, 1'b1}}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h12, 1'b0, CHK_WORD, OVR_WORD}},
    '{ROW_CFG,  REG_ROW_PIXELS, 32'd2, CFG_ONLY},
    '{ROW_CFG,  REG_BPP,        32'd1, CFG_ONLY},
    '{ROW_CFG,  REG_IMAGE_ROWS, 32'd4, CFG_ONLY},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h01, 1'b1, CHK_PRED, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h10, 1'b0, CHK_PRED, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'hF5, 1'b0, CHK_PRED, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h02, 1'b0, CHK_PRED, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h01, 1'b0, CHK_PRED, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h02, 1'b0, CHK_PRED, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h03, 1'b0, CHK_PRED, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'hFF, 1'b0, CHK_PRED, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h80, 1'b0, CHK_PRED, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h04, 1'b0, CHK_PRED, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h7C, 1'b0, CHK_PRED, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h9E, 1'b0, CHK_PRED, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h07, 1'b1, CHK_WORD, BAD_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h33, 1'b0, CHK_WORD, BAD_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h02, 1'b1, CHK_NONE, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0,
      '{8'h44, 1'b0, CHK_WORD, '{8'h44, ST_OK, 1'b0, 1'b0}}},
    '{ROW_CFG,  REG_ROW_PIXELS, 32'd1, CFG_ONLY},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h55, 1'b0, CHK_WORD, OVR_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h00, 1'b0, CHK_NONE, NO_WORD}},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h09, 1'b0, CHK_PRED, NO_WORD}},
    '{ROW_CFG,  REG_ROW_PIXELS, 32'd0, CFG_ONLY},
    '{ROW_WORD, REG_ROW_PIXELS, 32'd0, '{8'h5A, 1'b1, CHK_WORD, OVR_WORD}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  filtered_byte = 8'h00;
  logic        image_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pixel_byte;
  logic [1:0]  status;
  logic        row_end;
  logic        image_end;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  png_scanline_unfilter_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .filtered_byte_i (filtered_byte),
    .image_start_i   (image_start),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .pixel_byte_o    (pixel_byte),
    .status_o        (status),
    .row_end_o       (row_end),
    .image_end_o     (image_end),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk = ~clk;

  initial begin
    #(20_000_000);
    $display("simulation failed");
    $finish;
  end

  logic [ROWPIX_W-1:0] cfg_row_pixels = ROWPIX_W'(1);
  logic [BPP_W-1:0]    cfg_bpp = BPP_W'(4);
  logic [ROWS_W-1:0]   cfg_rows = ROWS_W'(1);

  logic [7:0] above_row [MAX_ROW_BYTES];
  logic [7:0] left_hist [MAX_PIXEL_BYTES];
  logic [7:0] upleft_hist [MAX_PIXEL_BYTES];
  int         col_cnt;
  int         row_cnt;
  logic [2:0] filt;
  bit         first_row;
  bit         err_flag;

  feed_word_t  byte_q [$];
  pixel_word_t pixel_q [$];
  feed_word_t  cur_word = '0;
  int          pushed_words = 0;
  int          mismatch_cnt = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  rx_mode_e    rx_mode = RX_FREE;
  int          mode_left = 0;

  function automatic void clear_image();
    for (int n = 0; n < MAX_PIXEL_BYTES; n++) begin
      left_hist[n] = 8'h00;
      upleft_hist[n] = 8'h00;
    end
    col_cnt = 0;
    row_cnt = 0;
    filt = FILT_NONE;
    first_row = 1'b1;
    err_flag = 1'b0;
  endfunction

  function automatic void unfilter_step(input logic [7:0] fb, input logic start,
                                        output bit has, output pixel_word_t res);
    int line_len, i, k, a, b, c, pred, p, pa, pb, pc;
    logic [7:0] x;
    has = 1'b1;
    res = OVR_WORD;
    if (start) clear_image();
    line_len = int'(cfg_row_pixels) * int'(cfg_bpp);
    if (cfg_row_pixels == 0 || cfg_bpp == 0 || cfg_bpp > MAX_PIXEL_BYTES ||
        line_len > MAX_ROW_BYTES) return;
    if (err_flag) begin
      res = BAD_WORD;
      return;
    end
    if (row_cnt >= int'(cfg_rows)) return;
    if (col_cnt == 0) begin
      if (fb >= FILT_LIMIT) begin
        err_flag = 1'b1;
        res = BAD_WORD;
        return;
      end
      filt = fb[2:0];
      col_cnt = 1;
      has = 1'b0;
      return;
    end
    i = col_cnt - 1;
    if (i >= line_len) begin
      col_cnt = 0;
      return;
    end
    k = i % int'(cfg_bpp);
    a = (i >= int'(cfg_bpp)) ? int'(left_hist[k]) : 0;
    b = first_row ? 0 : int'(above_row[i]);
    c = (i >= int'(cfg_bpp) && !first_row) ? int'(upleft_hist[k]) : 0;
    case (filt)
      FILT_SUB: pred = a;
      FILT_UP: pred = b;
      FILT_AVG: pred = (a + b) >> 1;
      FILT_PAETH: begin
        p = a + b - c;
        pa = (p > a) ? p - a : a - p;
        pb = (p > b) ? p - b : b - p;
        pc = (p > c) ? p - c : c - p;
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc) pred = b;
        else pred = c;
      end
      default: pred = 0;
    endcase
    x = fb + pred[7:0];
    upleft_hist[k] = b[7:0];
    left_hist[k] = x;
    above_row[i] = x;
    res = '{x, ST_OK, 1'b0, 1'b0};
    if (col_cnt >= line_len) begin
      col_cnt = 0;
      first_row = 1'b0;
      if (row_cnt < 32'hFFFF) row_cnt++;
      res.row_end = 1'b1;
      res.image_end = (row_cnt >= int'(cfg_rows));
      return;
    end
    col_cnt++;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    bit          has;
    pixel_word_t res;
    pixel_word_t got;
    pixel_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        unfilter_step(cur_word.data, cur_word.start, has, res);
        if (cur_word.chk == CHK_WORD) pixel_q.push_back(cur_word.want);
        else if (cur_word.chk == CHK_PRED && has) pixel_q.push_back(res);
      end
      if (out_valid && out_ready) begin
        got = '{pixel_byte, status, row_end, image_end};
        if (pixel_q.size() == 0) begin
          report_mismatch("unexpected word", 32'(got), 32'd0);
        end else begin
          want = pixel_q.pop_front();
          if (got.px !== want.px)
            report_mismatch("pixel_byte", 32'(got.px), 32'(want.px));
          if (got.st !== want.st)
            report_mismatch("status", 32'(got.st), 32'(want.st));
          if (got.row_end !== want.row_end)
            report_mismatch("row_end", 32'(got.row_end), 32'(want.row_end));
          if (got.image_end !== want.image_end)
            report_mismatch("image_end", 32'(got.image_end), 32'(want.image_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    feed_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0 || byte_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        w = byte_q.pop_front();
        cur_word <= w;
        filtered_byte <= w.data;
        image_start <= w.start;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 64);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      mode_left <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_FREE: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (mode_left[1:0] == 2'd0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid || pixel_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    rdata = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] rd;
    wait_idle();
    case (idx)
      REG_ROW_PIXELS: mask = (32'd1 << ROWPIX_W) - 1;
      REG_BPP: mask = (32'd1 << BPP_W) - 1;
      default: mask = (32'd1 << ROWS_W) - 1;
    endcase
    apb_xfer(1'b1, idx, val, rd);
    case (idx)
      REG_ROW_PIXELS: cfg_row_pixels = val[ROWPIX_W-1:0];
      REG_BPP: cfg_bpp = val[BPP_W-1:0];
      default: cfg_rows = val[ROWS_W-1:0];
    endcase
    apb_xfer(1'b0, idx, 32'd0, rd);
    if (rd !== (val & mask)) report_mismatch("register readback", rd, val & mask);
  endtask

  function automatic logic [31:0] with_upper_noise(input int v, input int w);
    logic [31:0] noise;
    noise = ($urandom_range(0, 3) == 0) ? ($urandom << w) : 32'd0;
    return 32'(v) | noise;
  endfunction

  task automatic push_word(input logic [7:0] d, input logic s);
    byte_q.push_back('{d, s, CHK_PRED, NO_WORD});
    pushed_words++;
  endtask

  task automatic send_image(input int rows, input int line_len);
    bit cut;
    cut = 1'b0;
    for (int r = 0; r < rows && !cut; r++) begin
      push_word(8'(($urandom_range(0, 19) == 0) ? $urandom_range(5, 255)
                                                  : $urandom_range(0, 4)),
                r == 0);
      for (int j = 0; j < line_len; j++) begin
        if ($urandom_range(0, 499) == 0) begin
          cut = 1'b1;
          break;
        end
        push_word(8'($urandom_range(0, 255)), $urandom_range(0, 199) == 0);
      end
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) push_word(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    int  start_cnt, phase, pick, rp, bpp, rows, rb;
    bit  legal;
    clear_image();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < N_DIRECTED; n++) begin
      if (DIRECTED[n].kind == ROW_CFG) write_reg(DIRECTED[n].reg_idx, DIRECTED[n].value);
      else byte_q.push_back(DIRECTED[n].word);
    end

    phase = 0;
    start_cnt = pushed_words;
    while (pushed_words - start_cnt < RANDOM_WORDS) begin
      pick = (phase == 0) ? 65 : (phase == 1) ? 72 : (phase == 2) ? 88 :
             (phase == 3) ? 95 : $urandom_range(0, 99);
      rp = $urandom_range(1, 4);
      bpp = $urandom_range(1, 4);
      rows = $urandom_range(1, 4);
      if (pick < 60) begin
        rp = $urandom_range(1, 6);
        bpp = $urandom_range(1, 8);
      end else if (pick < 70) begin
        bpp = $urandom_range(0, 1) ? 8 : 1;
        rp = $urandom_range(1, 3);
      end else if (pick < 78) begin
        rows = 65535;
      end else if (pick < 86) begin
        rows = $urandom_range(5, 9);
      end else if (pick < 90) begin
        rows = 0;
      end else begin
        case ($urandom_range(0, 4))
          0: rp = 0;
          1: bpp = 0;
          2: bpp = $urandom_range(9, 15);
          3: begin
            rp = $urandom_range(16385, 32767);
            bpp = 1;
          end
          default: begin
            rp = $urandom_range(2049, 16384);
            bpp = 8;
          end
        endcase
      end
      write_reg(REG_ROW_PIXELS, with_upper_noise(rp, ROWPIX_W));
      write_reg(REG_BPP, with_upper_noise(bpp, BPP_W));
      write_reg(REG_IMAGE_ROWS, with_upper_noise(rows, ROWS_W));
      rb = rp * bpp;
      legal = rp != 0 && bpp != 0 && bpp <= MAX_PIXEL_BYTES && rb <= MAX_ROW_BYTES;
      repeat ($urandom_range(1, 3)) begin
        if (!legal) send_image(1, $urandom_range(2, 8));
        else if (rows == 0) send_image(1, rb);
        else if (rows == 65535) send_image($urandom_range(1, 4), rb);
        else send_image(rows, rb);
      end
      phase++;
    end

    wait_idle();
    if (mismatch_cnt == 0 && pixel_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/pngunf_pkg.sv
sv/pngunf_ram.sv
sv/pngunf_rem.sv
sv/pngunf_ctrl.sv
sv/pngunf_recon.sv
sv/png_scanline_unfilter_top.sv
verif/testbench.sv
